// File: hw/rtl/lsp_pkg.sv
// Lidar scan packet parser: shared constants, FSM state type and the
// command/status structs between controller and datapath.
// No dependencies.
package lsp_pkg;

    localparam logic [7:0]  SYNC_BYTE0  = 8'hAA;
    localparam logic [7:0]  SYNC_BYTE1  = 8'h55;

    localparam int          ANGLE_BINS  = 360;
    localparam int          BIN_W       = 9;
    localparam int          DIST_W      = 14;
    localparam int          DEPTH_W     = 15;
    localparam logic [14:0] DEPTH_RESET = 15'd16383;

    // 360 degrees in 1/128 degree units
    localparam logic [16:0] FULL_TURN   = 17'd46080;

    // step dividend: 32-bit span with 16 fraction bits below it
    localparam int          DIVD_W      = 48;
    localparam int          ACC_W       = 34;
    localparam int          DIV_STEPS   = 48;
    localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_TYPE,
        ST_COUNT,
        ST_SA_LO,
        ST_SA_HI,
        ST_EA_LO,
        ST_EA_HI,
        ST_CS_LO,
        ST_CS_HI,
        ST_DIV,
        ST_SMP_LO,
        ST_SMP_HI
    } t_state;

    typedef struct packed {
        logic ld_count;
        logic ld_sa_lo;
        logic ld_sa_hi;
        logic ld_ea_lo;
        logic ld_ea_hi;
        logic begin_scan;
        logic ld_low;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_sync0;
        logic is_sync1;
        logic type_odd;
        logic count_zero;
        logic count_one;
        logic div_done;
        logic last_smp;
        logic out_busy;
    } t_status;

endpackage

// File: hw/rtl/lsp_ctrl.sv
// Lidar scan packet parser: byte-phase controller FSM.
// Depends on lsp_pkg; drives lsp_dp through t_cmd, reads t_status.
module lsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    output logic             o_rx_ready,
    input  lsp_pkg::t_status i_status,
    output lsp_pkg::t_cmd    o_cmd
);

    lsp_pkg::t_state r_state, n_state;
    logic            r_sync, n_sync;
    logic            w_fire;

    assign w_fire = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsp_pkg::ST_HUNT;
            r_sync  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sync  <= n_sync;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sync  = 1'b0;
        unique case (r_state)
            lsp_pkg::ST_HUNT: begin
                n_sync = r_sync;
                if (w_fire) begin
                    if (r_sync && i_status.is_sync1) begin
                        n_state = lsp_pkg::ST_TYPE;
                        n_sync  = 1'b0;
                    end else begin
                        n_sync  = i_status.is_sync0;
                    end
                end
            end
            lsp_pkg::ST_TYPE: begin
                if (w_fire) begin
                    n_state = i_status.type_odd ? lsp_pkg::ST_HUNT : lsp_pkg::ST_COUNT;
                end
            end
            lsp_pkg::ST_COUNT:  if (w_fire) n_state = lsp_pkg::ST_SA_LO;
            lsp_pkg::ST_SA_LO:  if (w_fire) n_state = lsp_pkg::ST_SA_HI;
            lsp_pkg::ST_SA_HI:  if (w_fire) n_state = lsp_pkg::ST_EA_LO;
            lsp_pkg::ST_EA_LO:  if (w_fire) n_state = lsp_pkg::ST_EA_HI;
            lsp_pkg::ST_EA_HI:  if (w_fire) n_state = lsp_pkg::ST_CS_LO;
            lsp_pkg::ST_CS_LO:  if (w_fire) n_state = lsp_pkg::ST_CS_HI;
            lsp_pkg::ST_CS_HI: begin
                if (w_fire) begin
                    priority if (i_status.count_zero) n_state = lsp_pkg::ST_HUNT;
                    else if (i_status.count_one)      n_state = lsp_pkg::ST_SMP_LO;
                    else                              n_state = lsp_pkg::ST_DIV;
                end
            end
            lsp_pkg::ST_DIV: begin
                if (i_status.div_done) n_state = lsp_pkg::ST_SMP_LO;
            end
            lsp_pkg::ST_SMP_LO: if (w_fire) n_state = lsp_pkg::ST_SMP_HI;
            lsp_pkg::ST_SMP_HI: begin
                if (w_fire) begin
                    n_state = i_status.last_smp ? lsp_pkg::ST_HUNT : lsp_pkg::ST_SMP_LO;
                end
            end
            default: n_state = lsp_pkg::ST_HUNT;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_rx_ready = 1'b1;
        unique case (r_state)
            lsp_pkg::ST_DIV:    o_rx_ready = 1'b0;
            lsp_pkg::ST_SMP_HI: o_rx_ready = !i_status.out_busy;
            default:            o_rx_ready = 1'b1;
        endcase
        unique case (r_state)
            lsp_pkg::ST_COUNT:  o_cmd.ld_count   = w_fire;
            lsp_pkg::ST_SA_LO:  o_cmd.ld_sa_lo   = w_fire;
            lsp_pkg::ST_SA_HI:  o_cmd.ld_sa_hi   = w_fire;
            lsp_pkg::ST_EA_LO:  o_cmd.ld_ea_lo   = w_fire;
            lsp_pkg::ST_EA_HI:  o_cmd.ld_ea_hi   = w_fire;
            lsp_pkg::ST_CS_HI:  o_cmd.begin_scan = w_fire;
            lsp_pkg::ST_SMP_LO: o_cmd.ld_low     = w_fire;
            lsp_pkg::ST_SMP_HI: o_cmd.emit       = w_fire;
            default:            o_cmd            = '0;
        endcase
    end

endmodule

// File: hw/rtl/lsp_dp.sv
// Lidar scan packet parser: datapath with header fields, bit-serial step
// divider, angle accumulator and the output register. Depends on lsp_pkg.
module lsp_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_cfg_valid,
    input  logic [lsp_pkg::DEPTH_W-1:0] i_cfg_max_depth,
    input  lsp_pkg::t_cmd               i_cmd,
    output lsp_pkg::t_status            o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lsp_pkg::BIN_W-1:0]   o_bin_index,
    output logic [lsp_pkg::DIST_W-1:0]  o_distance,
    output logic                        o_last_sample
);

    // floor(a) mod 360 for an 11-bit whole-degree value (< 6 turns)
    function automatic logic [lsp_pkg::BIN_W-1:0] bin_wrap(input logic [10:0] a);
        logic [10:0] r;
        r = a;
        priority if (a >= 11'(5 * lsp_pkg::ANGLE_BINS)) r = a - 11'(5 * lsp_pkg::ANGLE_BINS);
        else if (a >= 11'(4 * lsp_pkg::ANGLE_BINS))     r = a - 11'(4 * lsp_pkg::ANGLE_BINS);
        else if (a >= 11'(3 * lsp_pkg::ANGLE_BINS))     r = a - 11'(3 * lsp_pkg::ANGLE_BINS);
        else if (a >= 11'(2 * lsp_pkg::ANGLE_BINS))     r = a - 11'(2 * lsp_pkg::ANGLE_BINS);
        else if (a >= 11'(lsp_pkg::ANGLE_BINS))         r = a - 11'(lsp_pkg::ANGLE_BINS);
        else                                            r = a;
        return r[lsp_pkg::BIN_W-1:0];
    endfunction

    logic [lsp_pkg::DEPTH_W-1:0]   r_max_depth;
    logic [7:0]                    r_count;
    logic [7:0]                    r_left;
    logic [15:0]                   r_start;
    logic [15:0]                   r_end;
    logic [lsp_pkg::ACC_W-1:0]     r_step;
    logic [lsp_pkg::ACC_W-1:0]     r_accum;
    logic [7:0]                    r_low;

    logic                          r_div_busy;
    logic [lsp_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [lsp_pkg::DIVD_W-1:0]    r_dq;
    logic [7:0]                    r_rem;
    logic [7:0]                    r_divisor;

    logic                          r_out_valid;
    logic [lsp_pkg::BIN_W-1:0]     r_bin;
    logic [lsp_pkg::DIST_W-1:0]    r_dist;
    logic                          r_last;

    logic [16:0]                   w_end_adj;
    logic [31:0]                   w_span;
    logic [8:0]                    w_rem_sh;
    logic                          w_q_bit;
    logic [8:0]                    w_rem_sub;
    logic [lsp_pkg::DIVD_W-1:0]    w_quot;
    logic [lsp_pkg::DIST_W-1:0]    w_raw;

    // unwrap end angle past 360 degrees; the span wraps modulo 2^32 when
    // start lies more than a turn beyond end
    assign w_end_adj = (r_end < r_start) ? ({1'b0, r_end} + lsp_pkg::FULL_TURN)
                                         : {1'b0, r_end};
    assign w_span    = 32'(w_end_adj) - 32'(r_start);

    // one restoring-division step per cycle
    assign w_rem_sh  = {r_rem, r_dq[lsp_pkg::DIVD_W-1]};
    assign w_q_bit   = (w_rem_sh >= {1'b0, r_divisor});
    assign w_rem_sub = w_rem_sh - {1'b0, r_divisor};
    assign w_quot    = {r_dq[lsp_pkg::DIVD_W-2:0], w_q_bit};

    assign w_raw     = {i_rx_byte, r_low[7:2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= lsp_pkg::DEPTH_RESET;
        end else if (i_cfg_valid) begin
            r_max_depth <= i_cfg_max_depth;
        end
    end

    // header fields, accumulator, divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else begin
            if (i_cmd.ld_count) r_count        <= i_rx_byte;
            if (i_cmd.ld_sa_lo) r_start[7:0]   <= i_rx_byte;
            if (i_cmd.ld_sa_hi) r_start[15:8]  <= i_rx_byte;
            if (i_cmd.ld_ea_lo) r_end[7:0]     <= i_rx_byte;
            if (i_cmd.ld_ea_hi) r_end[15:8]    <= i_rx_byte;
            if (i_cmd.ld_low)   r_low          <= i_rx_byte;

            if (i_cmd.begin_scan) begin
                r_accum    <= {2'b00, r_start, 16'h0000};
                r_left     <= r_count;
                r_dq       <= {w_span, 16'h0000};
                r_rem      <= '0;
                r_divisor  <= r_count - 8'd1;
                r_div_cnt  <= lsp_pkg::DIV_CNT_W'(lsp_pkg::DIV_STEPS - 1);
                r_div_busy <= (r_count > 8'd1);
                r_step     <= '0;
            end else if (r_div_busy) begin
                r_rem <= w_q_bit ? w_rem_sub[7:0] : w_rem_sh[7:0];
                r_dq  <= w_quot;
                if (r_div_cnt == '0) begin
                    r_div_busy <= 1'b0;
                    r_step     <= w_quot[lsp_pkg::ACC_W-1:0];
                end else begin
                    r_div_cnt  <= r_div_cnt - 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_accum <= r_accum + r_step;
                r_left  <= r_left - 8'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_bin  <= bin_wrap(r_accum[lsp_pkg::ACC_W-1:23]);
            r_dist <= ({1'b0, w_raw} >= r_max_depth) ? '0 : w_raw;
            r_last <= (r_left == 8'd1);
        end
    end

    assign o_status.is_sync0   = (i_rx_byte == lsp_pkg::SYNC_BYTE0);
    assign o_status.is_sync1   = (i_rx_byte == lsp_pkg::SYNC_BYTE1);
    assign o_status.type_odd   = i_rx_byte[0];
    assign o_status.count_zero = (r_count == 8'd0);
    assign o_status.count_one  = (r_count == 8'd1);
    assign o_status.div_done   = r_div_busy && (r_div_cnt == '0);
    assign o_status.last_smp   = (r_left == 8'd1);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_bin_index   = r_bin;
    assign o_distance    = r_dist;
    assign o_last_sample = r_last;

endmodule

// File: hw/rtl/lidar_scan_packet_parser.sv
// Lidar scan packet parser top level: joins the phase controller and the
// datapath. Depends on lsp_pkg, lsp_ctrl, lsp_dp.
//
//  channel  dir  handshake                 payload
//  rx       in   i_rx_valid / o_rx_ready   i_rx_byte[7:0]
//  out      out  o_out_valid / i_out_ready o_bin_index[8:0], o_distance[13:0],
//                                          o_last_sample
//  cfg      in   i_cfg_valid / o_cfg_ready i_cfg_max_depth[14:0]
//
// One received byte per cycle, except during the stalls below. After the checksum
// of a packet with two or more samples, the rx side holds off while the bit-serial
// divider works out the per-sample angle step.
// A sample high byte stalls only when the previous result is still
// waiting in the output register and not being taken.
// Synchronous active-low reset: FSM to header search, output empty,
// max_depth to 16383. No memory, so no clearing pass.
module lidar_scan_packet_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // received bytes
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [7:0]                  i_rx_byte,
    // sample results
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lsp_pkg::BIN_W-1:0]   o_bin_index,
    output logic [lsp_pkg::DIST_W-1:0]  o_distance,
    output logic                        o_last_sample,
    // max_depth write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lsp_pkg::DEPTH_W-1:0] i_cfg_max_depth
);

    lsp_pkg::t_cmd    w_cmd;
    lsp_pkg::t_status w_status;

    // the user writes the register only while idle, the block does not enforce it; every transfer is taken at once
    assign o_cfg_ready = 1'b1;

    lsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lsp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_max_depth (i_cfg_max_depth),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_bin_index     (o_bin_index),
        .o_distance      (o_distance),
        .o_last_sample   (o_last_sample)
    );

endmodule

// File: hw/rtl/lsp_chk.sv
// Lidar scan packet parser: port-level checker and its bind to the top.
// Depends on lidar_scan_packet_parser ports only.
module lsp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        o_rx_ready,
    input logic [7:0]  i_rx_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [8:0]  o_bin_index,
    input logic [13:0] o_distance,
    input logic        o_last_sample,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [14:0] i_cfg_max_depth
);

    // reset leaves the output empty and the parser taking bytes
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_rx_ready)
        else $error("output not empty or rx not ready after reset");

    // a new result appears only on the transfer of a byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_rx_valid && o_rx_ready))
        else $error("result without a received byte");

    // bin stays within one turn
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_bin_index < 9'd360)
        else $error("bin index out of range");

    // held result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable({o_bin_index, o_distance, o_last_sample}))
        else $error("stalled result changed");

endmodule

bind lidar_scan_packet_parser lsp_chk u_lsp_chk (.*);

// File: sim/lidar_scan_packet_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lidar_scan_packet_parser: drives lidar byte streams,
// predicts every sample result and checks bin, distance and last flag.
// Depends on lsp_pkg and the parser RTL.
module lidar_scan_packet_parser_tb;

    localparam int     DRAIN_CYCLES    = 60;    // covers the step divider
    localparam int     HOLD_OFF_CYCLES = 300;   // long output stall for the pressure test
    localparam int     BYTES_PER_LEG   = 175;
    localparam longint TIMEOUT_NS      = 4_000_000;

    typedef struct packed {
        logic [lsp_pkg::BIN_W-1:0]  bin_idx;
        logic [lsp_pkg::DIST_W-1:0] dist_val;
        logic                       last;
    } t_sample;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                         i_clk;
    logic                         i_rst_n         = 1'b0;
    logic                         i_rx_valid      = 1'b0;
    logic                         o_rx_ready;
    logic [7:0]                   i_rx_byte       = 8'h00;
    logic                         o_out_valid;
    logic                         i_out_ready     = 1'b0;
    logic [lsp_pkg::BIN_W-1:0]    o_bin_index;
    logic [lsp_pkg::DIST_W-1:0]   o_distance;
    logic                         o_last_sample;
    logic                         i_cfg_valid     = 1'b0;
    logic                         o_cfg_ready;
    logic [lsp_pkg::DEPTH_W-1:0]  i_cfg_max_depth = lsp_pkg::DEPTH_RESET;

    lidar_scan_packet_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_bin_index     (o_bin_index),
        .o_distance      (o_distance),
        .o_last_sample   (o_last_sample),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_depth (i_cfg_max_depth)
    );

    // ------------------------------------------------------------------
    // Parser shadow state, mirrors the block after reset
    // ------------------------------------------------------------------
    lsp_pkg::t_state             pr_phase  = lsp_pkg::ST_HUNT;
    logic                        pr_sync   = 1'b0;
    logic [7:0]                  pr_count  = '0;
    logic [7:0]                  pr_left   = '0;
    logic [15:0]                 pr_start  = '0;
    logic [16:0]                 pr_end    = '0;
    logic [lsp_pkg::ACC_W-1:0]   pr_step   = '0;
    logic [lsp_pkg::ACC_W-1:0]   pr_accum  = '0;
    logic [7:0]                  pr_low    = '0;
    logic [lsp_pkg::DEPTH_W-1:0] pr_depth  = lsp_pkg::DEPTH_RESET;

    // predicted samples, oldest first
    t_sample expected_samples[$];

    int   n_bytes           = 0;
    int   n_packets         = 0;
    int   n_samples_checked = 0;
    int   n_errors          = 0;
    int   n_depths          = 0;
    int   rx_idle_pct       = 0;
    int   out_stall_pct     = 0;
    logic holding           = 1'b0;
    event hold_go;

    // max_depth per leg; leg 0 keeps the reset value, the last leg is random
    logic [lsp_pkg::DEPTH_W-1:0] depth_plan [8] = '{lsp_pkg::DEPTH_RESET, 15'd0, 15'h7FFF,
                                                    15'd16384, 15'd1, 15'd8191, 15'd16383,
                                                    15'd5000};

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("lidar_scan_packet_parser verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= !holding && ($urandom_range(99) >= out_stall_pct);
    end

    // hold-off length is counted here so the sender keeps pushing meanwhile
    initial begin
        forever begin
            @(hold_go);
            holding <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Byte-level parser prediction; pushes one sample per sample high byte
    // ------------------------------------------------------------------
    function automatic void predict_byte(input logic [7:0] b);
        logic [31:0]                span;
        logic [63:0]                quot;
        logic [15:0]                raw;
        logic [lsp_pkg::DIST_W-1:0] dist_val;
        logic [10:0]                deg;
        t_sample                    s;
        case (pr_phase)
            lsp_pkg::ST_HUNT: begin
                if (pr_sync && b == lsp_pkg::SYNC_BYTE1) begin
                    pr_sync  = 1'b0;
                    pr_phase = lsp_pkg::ST_TYPE;
                end else begin
                    pr_sync = (b == lsp_pkg::SYNC_BYTE0);
                end
            end
            lsp_pkg::ST_TYPE: begin
                // odd type drops the packet
                if (b[0]) begin
                    pr_phase = lsp_pkg::ST_HUNT;
                    pr_sync  = 1'b0;
                end else begin
                    pr_phase = lsp_pkg::ST_COUNT;
                end
            end
            lsp_pkg::ST_COUNT: begin
                pr_count = b;
                pr_phase = lsp_pkg::ST_SA_LO;
            end
            lsp_pkg::ST_SA_LO: begin
                pr_start = {8'h00, b};
                pr_phase = lsp_pkg::ST_SA_HI;
            end
            lsp_pkg::ST_SA_HI: begin
                pr_start[15:8] = b;
                pr_phase       = lsp_pkg::ST_EA_LO;
            end
            lsp_pkg::ST_EA_LO: begin
                pr_end   = {9'h000, b};
                pr_phase = lsp_pkg::ST_EA_HI;
            end
            lsp_pkg::ST_EA_HI: begin
                pr_end[15:8] = b;
                pr_phase     = lsp_pkg::ST_CS_LO;
            end
            lsp_pkg::ST_CS_LO: pr_phase = lsp_pkg::ST_CS_HI;
            lsp_pkg::ST_CS_HI: begin
                // checksum skipped; set up the angle sweep
                if (pr_end < {1'b0, pr_start})
                    pr_end = pr_end + lsp_pkg::FULL_TURN;
                // span may still wrap when start is beyond a full turn
                span = 32'(pr_end) - 32'(pr_start);
                if (pr_count > 8'd1) begin
                    quot    = {16'h0000, span, 16'h0000} / 64'(pr_count - 8'd1);
                    pr_step = quot[lsp_pkg::ACC_W-1:0];
                end else begin
                    pr_step = '0;
                end
                pr_accum = {2'b00, pr_start, 16'h0000};
                pr_left  = pr_count;
                if (pr_left == 8'd0) begin
                    pr_phase = lsp_pkg::ST_HUNT;
                    pr_sync  = 1'b0;
                end else begin
                    pr_phase = lsp_pkg::ST_SMP_LO;
                end
            end
            lsp_pkg::ST_SMP_LO: begin
                pr_low   = b;
                pr_phase = lsp_pkg::ST_SMP_HI;
            end
            lsp_pkg::ST_SMP_HI: begin
                raw      = {b, pr_low};
                dist_val = raw[15:2];
                if ({1'b0, dist_val} >= pr_depth)
                    dist_val = '0;
                deg        = pr_accum[33:23];
                s.bin_idx  = lsp_pkg::BIN_W'(deg % lsp_pkg::ANGLE_BINS);
                s.dist_val = dist_val;
                pr_accum   = pr_accum + pr_step;
                pr_left    = pr_left - 8'd1;
                s.last     = (pr_left == 8'd0);
                if (s.last) begin
                    pr_phase = lsp_pkg::ST_HUNT;
                    pr_sync  = 1'b0;
                end else begin
                    pr_phase = lsp_pkg::ST_SMP_LO;
                end
                expected_samples.push_back(s);
            end
            default: begin
                pr_phase = lsp_pkg::ST_HUNT;
                pr_sync  = 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: each transfer against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        if (got_v !== want_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : check_samples
        t_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected sample, expected none, actual bin %0d dist %0d last %0d",
                         $time, o_bin_index, o_distance, o_last_sample);
            end else begin
                want = expected_samples.pop_front();
                n_samples_checked++;
                report_field("bin_index", 32'(want.bin_idx), 32'(o_bin_index));
                report_field("distance", 32'(want.dist_val), 32'(o_distance));
                report_field("last_sample", 32'(want.last), 32'(o_last_sample));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One byte transfer, with random idle cycles ahead of it. Called and
    // returns on a rising edge; prediction runs once the transfer happened.
    task automatic send_byte(input logic [7:0] b);
        while (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        predict_byte(b);
        n_bytes++;
    endtask

    // Full scan packet; half the time a realistic sweep, else raw 16-bit angles.
    task automatic send_scan_packet(input int count, input logic odd_type);
        logic [15:0] sa;
        logic [15:0] ea;
        logic [15:0] raw;
        logic [7:0]  kind;
        int          d;
        if ($urandom_range(1)) begin
            sa = 16'($urandom_range(46079));
            ea = 16'((sa + $urandom_range(3000)) % 46080);
        end else begin
            sa = 16'($urandom);
            ea = 16'($urandom);
        end
        kind    = 8'($urandom);
        kind[0] = odd_type;
        send_byte(lsp_pkg::SYNC_BYTE0);
        send_byte(lsp_pkg::SYNC_BYTE1);
        send_byte(kind);
        send_byte(8'(count));
        send_byte(sa[7:0]);
        send_byte(sa[15:8]);
        send_byte(ea[7:0]);
        send_byte(ea[15:8]);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        for (int k = 0; k < count; k++) begin
            // a quarter of the samples sit right at the depth threshold
            if ($urandom_range(3) == 0) begin
                d   = int'(pr_depth) + int'($urandom_range(2)) - 1;
                raw = 16'((d << 2) | int'($urandom_range(3)));
            end else begin
                raw = 16'($urandom);
            end
            send_byte(raw[7:0]);
            send_byte(raw[15:8]);
        end
        n_packets++;
    endtask

    // Line noise, heavy on sync bytes so false and split headers show up
    task automatic send_noise(input int len);
        int r;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(3);
            if (r == 0)
                send_byte(lsp_pkg::SYNC_BYTE0);
            else if (r == 1)
                send_byte(lsp_pkg::SYNC_BYTE1);
            else
                send_byte(8'($urandom));
        end
    endtask

    // Run the parser back to header search with zero bytes (a zero count
    // ends a packet at its checksum), then wait for every sample to drain.
    task automatic settle_idle();
        while (pr_phase != lsp_pkg::ST_HUNT) send_byte(8'h00);
        i_rx_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_depth(input logic [lsp_pkg::DEPTH_W-1:0] value);
        settle_idle();
        i_cfg_valid     <= 1'b1;
        i_cfg_max_depth <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        pr_depth = value;
        n_depths++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Sync hunt: a broken pair, a double 0xAA re-arm, then an odd type that
    // drops the packet.
    task automatic test_header_sync();
        logic [7:0] seq [7] = '{8'hAA, 8'h00, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'h01};
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    // Zero samples: back to hunt after the checksum, no result
    task automatic test_empty_packet();
        logic [7:0] seq [10] = '{8'hAA, 8'h55, 8'h02, 8'h00, 8'h00, 8'h00,
                                 8'hFF, 8'hFF, 8'hFF, 8'h00};
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    // Single sample: zero step, end below start, all-ones angle and sample
    task automatic test_single_sample();
        logic [7:0] seq [12] = '{8'hAA, 8'h55, 8'h00, 8'h01, 8'hFF, 8'hFF,
                                 8'h00, 8'h00, 8'h5A, 8'hA5, 8'hFF, 8'hFF};
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    // Mostly well-formed packets with random content; the rest odd types,
    // truncated packets and noise.
    task automatic test_random_traffic(input int budget);
        int start_bytes;
        int r;
        int c;
        start_bytes = n_bytes;
        while (n_bytes - start_bytes < budget) begin
            r = $urandom_range(99);
            if (r < 78) begin
                c = $urandom_range(99);
                if (c < 1)
                    c = $urandom_range(255, 32);
                else if (c < 8)
                    c = 0;
                else if (c < 18)
                    c = 1;
                else
                    c = $urandom_range(12, 2);
                send_scan_packet(c, 1'b0);
            end else if (r < 86) begin
                send_scan_packet($urandom_range(3), 1'b1);
            end else if (r < 94) begin
                // header, even type, small count, then cut short by noise
                send_byte(lsp_pkg::SYNC_BYTE0);
                send_byte(lsp_pkg::SYNC_BYTE1);
                send_byte(8'($urandom) & 8'hFE);
                send_byte(8'($urandom_range(4)));
                send_noise($urandom_range(6, 1));
            end else begin
                send_noise($urandom_range(6, 1));
            end
        end
    endtask

    // Output held off for a long stretch while a max-count packet streams in:
    // the result register fills and the parser has to stall its input.
    task automatic test_backpressure();
        rx_idle_pct   = 0;
        out_stall_pct = 0;
        -> hold_go;
        send_scan_packet(255, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run
        int leg;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_sync();
        test_empty_packet();
        test_single_sample();

        depth_plan[7] = lsp_pkg::DEPTH_W'($urandom_range(16384));
        for (leg = 0; leg < 8; leg++) begin
            if (leg != 0)
                set_max_depth(depth_plan[leg]);
            // four handshake mixes, each seen under two depth settings
            case (leg % 4)
                0: begin
                    rx_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    rx_idle_pct   = 65;
                    out_stall_pct = 0;
                end
                2: begin
                    rx_idle_pct   = 0;
                    out_stall_pct = 65;
                end
                default: begin
                    rx_idle_pct   = 38;
                    out_stall_pct = 38;
                end
            endcase
            test_random_traffic(BYTES_PER_LEG);
        end

        test_backpressure();
        settle_idle();

        $display("Run covered %0d bytes in %0d scan packets, %0d samples checked,",
                 n_bytes, n_packets, n_samples_checked);
        $display("%0d mismatches, four handshake mixes, a %0d-cycle hold-off, %0d depth writes",
                 n_errors, HOLD_OFF_CYCLES, n_depths);
        if (n_errors == 0 && expected_samples.size() == 0) begin
            $display("lidar_scan_packet_parser verification clean");
        end else begin
            $display("lidar_scan_packet_parser verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_ctrl.sv
hw/rtl/lsp_dp.sv
hw/rtl/lidar_scan_packet_parser.sv
hw/rtl/lsp_chk.sv
sim/lidar_scan_packet_parser_tb.sv
